@@ rtl/u8u16_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder package
// Shared types and constants for the byte front end, the record queue and the
// UTF-16 unit back end.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  // Widths of the code point and of one UTF-16 unit.
  localparam int unsigned CP_W   = 21;
  localparam int unsigned UNIT_W = 16;

  // Largest legal code point and the replacement character.
  localparam logic [CP_W-1:0]   MAX_CODE_POINT = 21'h10FFFF;
  localparam logic [CP_W-1:0]   BMP_LIMIT      = 21'h010000;
  localparam logic [UNIT_W-1:0] REPLACEMENT    = 16'hFFFD;

  // Surrogate prefixes (top six bits of a surrogate half).
  localparam logic [5:0] HIGH_SURR_PFX = 6'b110110;
  localparam logic [5:0] LOW_SURR_PFX  = 6'b110111;

  // Lead byte patterns, compared on the top bits of the byte.
  localparam logic [2:0] LEAD2_PFX = 3'b110;
  localparam logic [3:0] LEAD3_PFX = 4'b1110;
  localparam logic [4:0] LEAD4_PFX = 5'b11110;

  // Following bytes still expected after a lead byte.
  localparam logic [1:0] LEFT_NONE = 2'd0;
  localparam logic [1:0] LEFT_ONE  = 2'd1;
  localparam logic [1:0] LEFT_TWO  = 2'd2;
  localparam logic [1:0] LEFT_THR  = 2'd3;

  // One decoded code point on its way from the front end to the back end.
  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            done;
    logic            trunc;
  } cp_rec_t;

  // Queue status seen by both ends.
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage
`default_nettype wire

@@ rtl/u8u16_ifs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder stream interfaces
// Valid/ready channels for the input byte stream and the UTF-16 unit stream.
// ----------------------------------------------------------------------------

// Byte channel: one UTF-8 byte per beat.
interface u8u16_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

// Unit channel: one UTF-16 code unit per beat.
interface u8u16_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] unit;
  logic        last_unit;
  logic        string_done;
  logic        truncated;
  logic        out_of_range;

  modport source (output valid, output unit, output last_unit, output string_done,
                  output truncated, output out_of_range, input ready);
  modport sink   (input valid, input unit, input last_unit, input string_done,
                  input truncated, input out_of_range, output ready);
endinterface
`default_nettype wire

@@ rtl/u8u16_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder front end
// Accepts bytes, tracks the multi-byte sequence state and pushes each finished
// (or cut short) code point into the record queue.
// ----------------------------------------------------------------------------
module u8u16_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  u8u16_byte_if.sink             in_ch,
  input  wire u8u16_pkg::q_stat_t q_stat,
  output logic                   push,
  output u8u16_pkg::cp_rec_t     rec
);

  logic [1:0]                  bytes_left_r, bytes_left_nxt;
  logic [u8u16_pkg::CP_W-1:0]  acc_r, acc_nxt;
  logic [u8u16_pkg::CP_W-1:0]  acc_or;
  logic                        accept;
  logic                        emit;
  logic [7:0]                  b;
  logic                        eos;

  assign b   = in_ch.in_byte;
  assign eos = in_ch.end_of_string;

  // A beat is taken whenever the queue has room.
  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push        = accept && emit;

  // Merge the low six bits of a following byte at the slot set by bytes_left.
  always_comb begin
    unique case (bytes_left_r)
      u8u16_pkg::LEFT_ONE: acc_or = acc_r | u8u16_pkg::CP_W'(b[5:0]);
      u8u16_pkg::LEFT_TWO: acc_or = acc_r | (u8u16_pkg::CP_W'(b[5:0]) << 6);
      u8u16_pkg::LEFT_THR: acc_or = acc_r | (u8u16_pkg::CP_W'(b[5:0]) << 12);
      default:             acc_or = acc_r;
    endcase
  end

  // Classify the byte and work out the next state and the record to push.
  always_comb begin
    bytes_left_nxt = bytes_left_r;
    acc_nxt        = acc_r;
    emit           = 1'b0;
    rec.cp         = acc_r;
    rec.done       = eos;
    rec.trunc      = 1'b0;
    if (bytes_left_r != u8u16_pkg::LEFT_NONE) begin
      // Following byte, taken without checking its top bits.
      rec.cp         = acc_or;
      acc_nxt        = acc_or;
      bytes_left_nxt = bytes_left_r - 2'd1;
      if (bytes_left_r == u8u16_pkg::LEFT_ONE) begin
        emit    = 1'b1;
        acc_nxt = '0;
      end else if (eos) begin
        emit           = 1'b1;
        rec.trunc      = 1'b1;
        bytes_left_nxt = u8u16_pkg::LEFT_NONE;
        acc_nxt        = '0;
      end
    end else begin
      priority if (!b[7]) begin
        // Plain ASCII goes straight out.
        emit   = 1'b1;
        rec.cp = u8u16_pkg::CP_W'(b[6:0]);
      end else if (b[7:5] == u8u16_pkg::LEAD2_PFX) begin
        rec.cp         = {10'd0, b[4:0], 6'd0};
        bytes_left_nxt = u8u16_pkg::LEFT_ONE;
      end else if (b[7:4] == u8u16_pkg::LEAD3_PFX) begin
        rec.cp         = {5'd0, b[3:0], 12'd0};
        bytes_left_nxt = u8u16_pkg::LEFT_TWO;
      end else if (b[7:3] == u8u16_pkg::LEAD4_PFX) begin
        rec.cp         = {b[2:0], 18'd0};
        bytes_left_nxt = u8u16_pkg::LEFT_THR;
      end else begin
        // Stray continuation byte or invalid lead: skipped.
        bytes_left_nxt = u8u16_pkg::LEFT_NONE;
      end
      if (b[7] && bytes_left_nxt != u8u16_pkg::LEFT_NONE) begin
        if (eos) begin
          // A lead byte that ends the string goes out cut short.
          emit           = 1'b1;
          rec.trunc      = 1'b1;
          bytes_left_nxt = u8u16_pkg::LEFT_NONE;
          acc_nxt        = '0;
        end else begin
          acc_nxt = rec.cp;
        end
      end
    end
  end

  // Sequence state advances only on an accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= u8u16_pkg::LEFT_NONE;
      acc_r        <= '0;
    end else if (accept) begin
      bytes_left_r <= bytes_left_nxt;
      acc_r        <= acc_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/u8u16_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder record queue
// Small register FIFO of code point records between front and back end.
// ----------------------------------------------------------------------------
module u8u16_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire u8u16_pkg::cp_rec_t wr_rec,
  input  wire logic               pop,
  output u8u16_pkg::cp_rec_t      head,
  output u8u16_pkg::q_stat_t      q_stat
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  u8u16_pkg::cp_rec_t mem_r [DEPTH];
  logic [AW-1:0]      wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]      cnt_r;

  assign head         = mem_r[rd_ptr_r];
  assign q_stat.empty = (cnt_r == '0);
  assign q_stat.full  = (cnt_r == FULL_CNT);

  // Storage: written at the tail, no reset needed.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_rec;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/u8u16_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder back end
// Range checks each code point and emits one UTF-16 unit, or a surrogate pair
// over two beats, through a registered output stage.
// ----------------------------------------------------------------------------
module u8u16_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire u8u16_pkg::cp_rec_t head,
  input  wire u8u16_pkg::q_stat_t q_stat,
  output logic                    pop,
  u8u16_unit_if.source            out_ch
);

  logic                          out_valid_r;
  logic [u8u16_pkg::UNIT_W-1:0]  unit_r, unit_nxt;
  logic                          last_r, last_nxt;
  logic                          done_r, trunc_r, oor_r, oor_nxt;
  logic                          half_r, half_nxt;
  logic                          load;
  logic                          pair;
  logic [19:0]                   sv;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.unit         = unit_r;
  assign out_ch.last_unit    = last_r;
  assign out_ch.string_done  = done_r;
  assign out_ch.truncated    = trunc_r;
  assign out_ch.out_of_range = oor_r;

  // The output register takes a new unit when it is empty or being drained.
  assign load = (!out_valid_r || out_ch.ready) && !q_stat.empty;

  // Range check and surrogate split of the head record.
  assign oor_nxt = (head.cp > u8u16_pkg::MAX_CODE_POINT);
  assign pair    = !oor_nxt && (head.cp >= u8u16_pkg::BMP_LIMIT);
  assign sv      = 20'(head.cp - u8u16_pkg::BMP_LIMIT);

  always_comb begin
    half_nxt = half_r;
    pop      = 1'b0;
    last_nxt = 1'b1;
    if (oor_nxt) begin
      unit_nxt = u8u16_pkg::REPLACEMENT;
    end else begin
      unit_nxt = head.cp[u8u16_pkg::UNIT_W-1:0];
    end
    if (pair) begin
      if (!half_r) begin
        unit_nxt = {u8u16_pkg::HIGH_SURR_PFX, sv[19:10]};
        last_nxt = 1'b0;
      end else begin
        unit_nxt = {u8u16_pkg::LOW_SURR_PFX, sv[9:0]};
      end
    end
    if (load) begin
      if (pair && !half_r) begin
        half_nxt = 1'b1;
      end else begin
        half_nxt = 1'b0;
        pop      = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      half_r      <= 1'b0;
    end else begin
      half_r <= half_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (load) begin
      unit_r  <= unit_nxt;
      last_r  <= last_nxt;
      done_r  <= head.done;
      trunc_r <= head.trunc;
      oor_r   <= oor_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/utf8_to_utf16_stream_decoder.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 stream decoder
// Turns a UTF-8 byte stream into UTF-16 code units with per-unit flags.
// ----------------------------------------------------------------------------
// The block takes one UTF-8 byte per cycle while its record queue has room and
// gives one UTF-16 unit per cycle while the receiver is ready. A byte that
// finishes a code point is written into the record queue when it is taken; the
// unit generator then loads its unit into the registered output stage, from
// which it leaves on an output beat. A code point above 0xFFFF leaves as a
// surrogate pair, high half first, on two output beats. The record queue
// between the byte decoder and the unit generator (QUEUE_DEPTH entries) absorbs
// that extra beat, so input bytes keep flowing at one per cycle while the
// output is taken every cycle.
// Malformed sequences are not checked: following bytes give their low six
// bits, stray continuation bytes and 0xF8-0xFF leads are dropped, a sequence
// cut short by end of string leaves flagged as truncated, and values above
// 0x10FFFF leave as 0xFFFD flagged as out of range.
module utf8_to_utf16_stream_decoder #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  u8u16_byte_if.sink    in_ch,
  u8u16_unit_if.source  out_ch
);

  u8u16_pkg::cp_rec_t wr_rec;
  u8u16_pkg::cp_rec_t head;
  u8u16_pkg::q_stat_t q_stat;
  logic               push;
  logic               pop;

  // Byte decoder.
  u8u16_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_stat (q_stat),
    .push   (push),
    .rec    (wr_rec)
  );

  // Code point record queue.
  u8u16_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_rec (wr_rec),
    .pop    (pop),
    .head   (head),
    .q_stat (q_stat)
  );

  // UTF-16 unit generator.
  u8u16_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

`ifndef SYNTHESIS
  // A unit that is not the last of its code point is always a high surrogate.
  a_high_half: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.last_unit |-> out_ch.unit[15:10] == u8u16_pkg::HIGH_SURR_PFX)
    else $error("non-final unit is not a high surrogate");

  // Once a high half is taken, the low half follows on the very next cycle.
  a_low_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && !out_ch.last_unit |=>
      out_ch.valid && out_ch.unit[15:10] == u8u16_pkg::LOW_SURR_PFX)
    else $error("low surrogate did not follow its high half");

  // A replaced value is a single replacement character.
  a_oor_repl: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.out_of_range |->
      out_ch.unit == u8u16_pkg::REPLACEMENT && out_ch.last_unit)
    else $error("out of range value not replaced");

  // Truncation only happens at the end of a string.
  a_trunc_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.truncated |-> out_ch.string_done)
    else $error("truncated unit outside end of string");
`endif

endmodule
`default_nettype wire

@@ verif/utf8_to_utf16_stream_decoder_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 stream decoder checker
// Watches the byte and unit channels and decodes every accepted byte on its
// own. Each unit beat is compared field by field with the oldest expected
// unit. It reports the mismatch count and the number of units still owed.
// ----------------------------------------------------------------------------
module utf8_to_utf16_stream_decoder_checker (
  input  wire logic clk,
  input  wire logic rst_n,
  u8u16_byte_if     byte_mon,
  u8u16_unit_if     unit_mon,
  output int        mismatches,
  output int        units_pending
);

  // One UTF-16 unit beat with its flags, in port order.
  typedef struct packed {
    logic [u8u16_pkg::UNIT_W-1:0] unit;
    logic                         last_unit;
    logic                         string_done;
    logic                         truncated;
    logic                         out_of_range;
  } unit_beat_t;

  unit_beat_t                 expected_units[$];
  logic [1:0]                 seq_left;
  logic [u8u16_pkg::CP_W-1:0] point_bits;

  // Queue the unit or surrogate pair for one finished code point.
  task automatic push_code_point(input logic [u8u16_pkg::CP_W-1:0] cp, input logic done,
                                 input logic trunc);
    logic                       too_big;
    logic [u8u16_pkg::CP_W-1:0] offset;
    too_big = (cp > u8u16_pkg::MAX_CODE_POINT);
    if (too_big) begin
      cp = u8u16_pkg::CP_W'(u8u16_pkg::REPLACEMENT);
    end
    if (cp < u8u16_pkg::BMP_LIMIT) begin
      expected_units.push_back({cp[15:0], 1'b1, done, trunc, too_big});
    end else begin
      offset = cp - u8u16_pkg::BMP_LIMIT;
      expected_units.push_back({u8u16_pkg::HIGH_SURR_PFX, offset[19:10], 1'b0, done,
                                trunc, too_big});
      expected_units.push_back({u8u16_pkg::LOW_SURR_PFX, offset[9:0], 1'b1, done,
                                trunc, too_big});
    end
  endtask

  // Advance the decoder state by one accepted byte.
  task automatic decode_utf8_byte(input logic [7:0] b, input logic eos);
    logic lead_ok;
    if (seq_left != u8u16_pkg::LEFT_NONE) begin
      // A following byte gives its low six bits, whatever its top bits are.
      point_bits = point_bits |
                   (u8u16_pkg::CP_W'(b[5:0]) << (6 * (int'(seq_left) - 1)));
      seq_left   = seq_left - 2'd1;
      if (seq_left == u8u16_pkg::LEFT_NONE) begin
        push_code_point(point_bits, eos, 1'b0);
        point_bits = '0;
      end else if (eos) begin
        push_code_point(point_bits, 1'b1, 1'b1);
        seq_left   = u8u16_pkg::LEFT_NONE;
        point_bits = '0;
      end
    end else if (!b[7]) begin
      push_code_point(u8u16_pkg::CP_W'(b), eos, 1'b0);
    end else begin
      // Lead byte; stray continuation bytes and 0xF8-0xFF are dropped.
      lead_ok = 1'b1;
      if (b[7:5] == u8u16_pkg::LEAD2_PFX) begin
        point_bits = {10'd0, b[4:0], 6'd0};
        seq_left   = u8u16_pkg::LEFT_ONE;
      end else if (b[7:4] == u8u16_pkg::LEAD3_PFX) begin
        point_bits = {5'd0, b[3:0], 12'd0};
        seq_left   = u8u16_pkg::LEFT_TWO;
      end else if (b[7:3] == u8u16_pkg::LEAD4_PFX) begin
        point_bits = {b[2:0], 18'd0};
        seq_left   = u8u16_pkg::LEFT_THR;
      end else begin
        lead_ok = 1'b0;
      end
      // A lead byte that ends the string leaves as a truncated value.
      if (lead_ok && eos) begin
        push_code_point(point_bits, 1'b1, 1'b1);
        seq_left   = u8u16_pkg::LEFT_NONE;
        point_bits = '0;
      end
    end
  endtask

  // Predict on byte beats, compare on unit beats.
  always @(posedge clk) begin
    unit_beat_t got;
    unit_beat_t want;
    if (!rst_n) begin
      expected_units.delete();
      seq_left   = u8u16_pkg::LEFT_NONE;
      point_bits = '0;
      mismatches = 0;
    end else begin
      if (byte_mon.valid && byte_mon.ready) begin
        decode_utf8_byte(byte_mon.in_byte, byte_mon.end_of_string);
      end
      if (unit_mon.valid && unit_mon.ready) begin
        got = {unit_mon.unit, unit_mon.last_unit, unit_mon.string_done,
               unit_mon.truncated, unit_mon.out_of_range};
        if (expected_units.size() == 0) begin
          $display("%0t: unexpected unit beat: unit %h last %b done %b trunc %b range %b",
                   $time, got.unit, got.last_unit, got.string_done, got.truncated,
                   got.out_of_range);
          mismatches++;
        end else begin
          want = expected_units.pop_front();
          if (got !== want) begin
            $display("%0t: unit mismatch: expected unit %h last %b done %b trunc %b range %b",
                     $time, want.unit, want.last_unit, want.string_done, want.truncated,
                     want.out_of_range);
            $display("%0t:                   actual unit %h last %b done %b trunc %b range %b",
                     $time, got.unit, got.last_unit, got.string_done, got.truncated,
                     got.out_of_range);
            mismatches++;
          end
        end
      end
    end
    units_pending = expected_units.size();
  end

endmodule
`default_nettype wire

@@ verif/utf8_to_utf16_stream_decoder_test.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 stream decoder testbench
// Sends directed byte strings for the corner cases, then random strings made
// mostly of well-formed sequences with noise, cut-short endings and loose
// following bytes, under phases of sender idling and receiver stalls. The
// checker beside the block predicts every unit and counts the mismatches.
// ----------------------------------------------------------------------------
module utf8_to_utf16_stream_decoder_test;

  localparam int RANDOM_BYTES   = 1625;
  localparam int HOLD_CYCLES    = 200;
  localparam int DRAIN_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT = 2000;

  // Directed bytes as {end_of_string, byte}.
  localparam logic [8:0] DIRECTED_BYTES [25] = '{
    9'h000, 9'h17F,                 // ASCII extremes, the second ends a string
    9'h0C2, 9'h0A9,                 // two-byte sequence
    9'h0F0, 9'h09F, 9'h098, 9'h080, // surrogate pair
    9'h0F4, 9'h090, 9'h080, 9'h080, // above 0x10FFFF, replaced
    9'h180,                         // stray continuation byte at end of string
    9'h0FF,                         // invalid lead byte
    9'h1F8,                         // invalid lead byte at end of string
    9'h0C3, 9'h041,                 // ASCII taken as a following byte
    9'h0E2, 9'h182,                 // sequence cut short
    9'h1F7,                         // lone lead cut short and out of range
    9'h0C0, 9'h080,                 // overlong form
    9'h0ED, 9'h0A0, 9'h080          // lone surrogate value
  };

  logic clk;
  logic rst_n;
  logic hold_request;
  int   stall_pct;
  int   send_idle_pct;
  int   mismatches;
  int   units_pending;
  int   quiet_cycles;

  u8u16_byte_if byte_ch();
  u8u16_unit_if unit_ch();

  utf8_to_utf16_stream_decoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (byte_ch),
    .out_ch (unit_ch)
  );

  utf8_to_utf16_stream_decoder_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .byte_mon      (byte_ch),
    .unit_mon      (unit_ch),
    .mismatches    (mismatches),
    .units_pending (units_pending)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Following byte with the given low bits; now and then its top bits are random.
  function automatic logic [7:0] follow_byte(input logic [5:0] bits);
    if ($urandom_range(9) == 0) begin
      return {2'($urandom_range(3)), bits};
    end
    return {2'b10, bits};
  endfunction

  // Offer one byte after a random idle gap and hold it until its beat.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid         <= 1'b1;
    byte_ch.in_byte       <= b;
    byte_ch.end_of_string <= eos;
    @(posedge clk);
    while (!byte_ch.ready) begin
      @(posedge clk);
    end
  endtask

  // Receiver: random stalls, or one long hold-off when asked.
  initial begin
    bit hold_served;
    hold_served   = 1'b0;
    unit_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_served) begin
        hold_served = 1'b1;
        unit_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        unit_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Watchdog on cycles without any beat.
  always @(posedge clk) begin
    if (!rst_n || (byte_ch.valid && byte_ch.ready) || (unit_ch.valid && unit_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("utf8_to_utf16_stream_decoder_test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus and verdict.
  initial begin
    logic [7:0]  text[$];
    logic [20:0] cp;
    int          sent;
    int          phase;
    int          n_chars;
    int          pick;
    int          seq_len;
    bit          hold_done;

    byte_ch.valid         = 1'b0;
    byte_ch.in_byte       = '0;
    byte_ch.end_of_string = 1'b0;
    rst_n                 = 1'b0;
    hold_request          = 1'b0;
    stall_pct             = 0;
    send_idle_pct         = 0;
    sent                  = 0;
    hold_done             = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed corner cases at full rate.
    foreach (DIRECTED_BYTES[i]) begin
      send_byte(DIRECTED_BYTES[i][7:0], DIRECTED_BYTES[i][8]);
    end

    // Random strings; the idling pattern changes with progress.
    while (sent < RANDOM_BYTES) begin
      phase = sent * 5 / RANDOM_BYTES;
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct <= 0;  end
        1: begin send_idle_pct = 62; stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  stall_pct <= 62; end
        3: begin send_idle_pct = 35; stall_pct <= 35; end
        default: begin
          send_idle_pct = 0;
          stall_pct    <= 0;
          // Long receiver hold-off while bytes keep coming, to fill the queue.
          if (!hold_done) begin
            hold_request <= 1'b1;
            hold_done     = 1'b1;
          end
        end
      endcase

      text.delete();
      seq_len = 1;
      n_chars = $urandom_range(1, 10);
      for (int c = 0; c < n_chars; c++) begin
        pick = $urandom_range(99);
        if (pick < 30) begin
          text.push_back({1'b0, 7'($urandom_range(127))});
          seq_len = 1;
        end else if (pick < 50) begin
          // Includes overlong forms.
          cp = 21'($urandom_range('h7FF));
          text.push_back({u8u16_pkg::LEAD2_PFX, cp[10:6]});
          text.push_back(follow_byte(cp[5:0]));
          seq_len = 2;
        end else if (pick < 70) begin
          cp = 21'($urandom_range('hFFFF));
          text.push_back({u8u16_pkg::LEAD3_PFX, cp[15:12]});
          text.push_back(follow_byte(cp[11:6]));
          text.push_back(follow_byte(cp[5:0]));
          seq_len = 3;
        end else if (pick < 88) begin
          // Mostly legal supplementary points, sometimes past 0x10FFFF.
          if ($urandom_range(9) == 0) begin
            cp = 21'($urandom());
          end else begin
            cp = 21'($urandom_range('h10000, 'h10FFFF));
          end
          text.push_back({u8u16_pkg::LEAD4_PFX, cp[20:18]});
          text.push_back(follow_byte(cp[17:12]));
          text.push_back(follow_byte(cp[11:6]));
          text.push_back(follow_byte(cp[5:0]));
          seq_len = 4;
        end else begin
          text.push_back(8'($urandom_range(255)));
          seq_len = 1;
        end
      end
      // Sometimes the string ends inside its last sequence.
      if (seq_len > 1 && $urandom_range(99) < 20) begin
        repeat ($urandom_range(1, seq_len - 1)) void'(text.pop_back());
      end

      foreach (text[i]) begin
        send_byte(text[i], i == text.size() - 1);
      end
      sent += text.size();
    end

    byte_ch.valid <= 1'b0;
    stall_pct     <= 0;
    while (units_pending != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && units_pending == 0) begin
      $display("utf8_to_utf16_stream_decoder_test passed");
    end else begin
      $display("utf8_to_utf16_stream_decoder_test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
